// ===== hw/rtl/tgad_pkg.sv =====
`default_nettype none

package tgad_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DIM_W     = 16;
  localparam int CNT_W     = 32;
  localparam int REM_SAT_W = 9;
  localparam int HDR_RUN_BIT = 7;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [REM_SAT_W-1:0] REM_SAT_MAX = REM_SAT_W'(1 << (REM_SAT_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPRESSED    = 2'd0,
    REG_ALPHA_PRESENT = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             compressed;
    logic             alpha_present;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  // one decoded pixel waiting for clipping and output
  typedef struct packed {
    logic [BYTE_W-1:0]    red;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    blue;
    logic [BYTE_W-1:0]    alpha;
    logic [BYTE_W-1:0]    rep_raw;
    logic [BYTE_W-1:0]    pkt;
    logic [REM_SAT_W-1:0] rem_sat;
    logic                 comp;
    logic                 done;
  } pix_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgad_front.sv =====
`default_nettype none

module tgad_front
  import tgad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_tvalid,
  input  wire logic [BYTE_W-1:0] in_tdata,
  output logic                   in_tready,
  input  wire logic              q_full,
  output logic                   q_push,
  output pix_rec_t               q_rec
);

  logic              s0_valid_r, s0_valid_nxt;
  logic [BYTE_W-1:0] s0_byte_r;
  logic [CNT_W-1:0]  total_r;
  logic              expect_hdr_r, expect_hdr_nxt;
  logic              run_r, run_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic [1:0]        bip_r, bip_nxt;
  logic [CNT_W-1:0]  pd_r, pd_nxt;
  logic [BYTE_W-1:0] color_r [3];

  logic              advance;
  logic              is_hdr;
  logic              complete3;
  logic              complete4;
  logic              pix_done;
  logic [CNT_W-1:0]  remaining;
  logic [BYTE_W-1:0] pkt;
  logic [BYTE_W-1:0] rep_raw;
  logic              done;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;

  assign in_tready = !s0_valid_r || !q_full;
  assign advance   = s0_valid_r && !q_full;

  assign w_eff = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
  assign h_eff = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;

  assign is_hdr    = cfg.compressed && expect_hdr_r;
  assign complete3 = !is_hdr && (bip_r == 2'd2) && !cfg.alpha_present;
  assign complete4 = !is_hdr && (bip_r == 2'd3);
  assign pix_done  = complete3 || complete4;

  assign remaining = (pd_r < total_r) ? (total_r - pd_r) : CNT_W'(1);
  assign pkt       = (left_r == '0) ? BYTE_W'(1) : left_r;
  assign rep_raw   = (cfg.compressed && run_r) ? pkt : BYTE_W'(1);
  assign done      = CNT_W'(rep_raw) >= remaining;

  always_comb begin
    q_push        = advance && pix_done;
    q_rec.red     = complete3 ? s0_byte_r : color_r[2];
    q_rec.green   = color_r[1];
    q_rec.blue    = color_r[0];
    q_rec.alpha   = (complete4 && cfg.alpha_present) ? s0_byte_r : '0;
    q_rec.rep_raw = rep_raw;
    q_rec.pkt     = pkt;
    q_rec.rem_sat = (remaining > CNT_W'(REM_SAT_MAX)) ? REM_SAT_MAX : remaining[REM_SAT_W-1:0];
    q_rec.comp    = cfg.compressed;
    q_rec.done    = done;
  end

  always_comb begin
    s0_valid_nxt   = s0_valid_r;
    expect_hdr_nxt = expect_hdr_r;
    run_nxt        = run_r;
    left_nxt       = left_r;
    bip_nxt        = bip_r;
    pd_nxt         = pd_r;
    if (advance) begin
      s0_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s0_valid_nxt = 1'b1;
    end
    if (advance) begin
      if (is_hdr) begin
        run_nxt        = s0_byte_r[HDR_RUN_BIT];
        left_nxt       = {1'b0, s0_byte_r[HDR_RUN_BIT-1:0]} + BYTE_W'(1);
        expect_hdr_nxt = 1'b0;
        bip_nxt        = 2'd0;
      end else if (!pix_done) begin
        bip_nxt = bip_r + 2'd1;
      end else begin
        bip_nxt = 2'd0;
        if (cfg.compressed) begin
          if (run_r || pkt <= BYTE_W'(1)) begin
            left_nxt       = '0;
            expect_hdr_nxt = 1'b1;
          end else begin
            left_nxt = pkt - BYTE_W'(1);
          end
        end
        if (done) begin
          expect_hdr_nxt = 1'b1;
          run_nxt        = 1'b0;
          left_nxt       = '0;
          pd_nxt         = '0;
        end else begin
          pd_nxt = pd_r + CNT_W'(rep_raw);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      expect_hdr_r <= 1'b1;
      run_r        <= 1'b0;
      left_r       <= '0;
      bip_r        <= 2'd0;
      pd_r         <= '0;
      total_r      <= CNT_W'(1);
    end else begin
      s0_valid_r   <= s0_valid_nxt;
      expect_hdr_r <= expect_hdr_nxt;
      run_r        <= run_nxt;
      left_r       <= left_nxt;
      bip_r        <= bip_nxt;
      pd_r         <= pd_nxt;
      total_r      <= CNT_W'(w_eff) * CNT_W'(h_eff);
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_byte_r <= in_tdata;
    end
    if (advance && !is_hdr && bip_r != 2'd3) begin
      color_r[bip_r] <= s0_byte_r;
    end
  end

`ifndef SYNTHESIS
  a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_rec.done) |=> (pd_r == '0 && expect_hdr_r))
    else $error("pixel count not cleared at image end");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_count_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_rec.done) |-> (pd_r < total_r))
    else $error("non-final pixel past image total");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tgad_queue.sv =====
`default_nettype none

module tgad_queue
  import tgad_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire pix_rec_t wr_rec,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output pix_rec_t      rd_rec
);

  pix_rec_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_rec    = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + Q_CNT_W'(1)))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tgad_back.sv =====
`default_nettype none

module tgad_back
  import tgad_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_not_empty,
  input  wire pix_rec_t              q_rec,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [OUT_USER_W-1:0] user_r;
  logic [BYTE_W-1:0]     rep;
  logic                  overrun;

  assign q_pop = q_not_empty && (!out_valid_r || out_tready);

  // clip at the image end
  assign rep = ({1'b0, q_rec.rep_raw} > q_rec.rem_sat) ? q_rec.rem_sat[BYTE_W-1:0]
                                                       : q_rec.rep_raw;
  assign overrun = q_rec.comp && ({1'b0, q_rec.pkt} > q_rec.rem_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= {rep, q_rec.alpha, q_rec.blue, q_rec.green, q_rec.red};
      user_r <= {overrun, q_rec.done};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

`ifndef SYNTHESIS
  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1 -: BYTE_W] != '0 &&
                    out_tdata[OUT_DATA_W-1 -: BYTE_W] <= BYTE_W'(128)))
    else $error("repeat count out of range");

  a_raw_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_rec.comp) |=> (out_tuser[1] == 1'b0 &&
                                out_tdata[OUT_DATA_W-1 -: BYTE_W] == BYTE_W'(1)))
    else $error("raw pixel with overrun or repeat");

  a_overrun_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && overrun && q_rec.rep_raw == q_rec.pkt) |-> q_rec.done)
    else $error("clipped run does not end the image");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_pixel_decoder.sv =====
// channel  dir  handshake           tdata (lowest bit up)                 tuser
// in_      in   in_tvalid/tready    data_byte                             -
// out_     out  out_tvalid/tready   red, green, blue, alpha, repeat_count image_done, overrun
// cfg_     in   cfg_wr_en           cfg_index selects register, cfg_wdata -
//
// one byte per cycle sustained while the queue has room
// front takes the byte into an input register and decodes it from there into a 2-entry queue
// back clips the repeat count and holds the transaction in the output register
// rst_n synchronous, active low; clears decode state and configuration
// each side stalls on its own; in_tready falls only when the queue is full
`default_nettype none

module tga_rle_pixel_decoder
  import tgad_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BYTE_W-1:0]    in_tdata,   // data_byte
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_DATA_W-1:0]     out_tdata,  // red, green, blue, alpha, repeat_count
  output logic [OUT_USER_W-1:0]     out_tuser,  // image_done, overrun
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  pix_rec_t wr_rec;
  pix_rec_t rd_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compressed    <= 1'b0;
      cfg_r.alpha_present <= 1'b0;
      cfg_r.image_width   <= DIM_W'(1);
      cfg_r.image_height  <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COMPRESSED:    cfg_r.compressed    <= cfg_wdata[0];
        REG_ALPHA_PRESENT: cfg_r.alpha_present <= cfg_wdata[0];
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  tgad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tready (in_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (wr_rec)
  );

  tgad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_rec    (wr_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_rec    (rd_rec)
  );

  tgad_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rec       (rd_rec),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== verif/tga_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_tb;
  import tgad_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 900;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] rep;
    logic       done;
    logic       ovr;
  } pixel_t;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_STARVED} rdy_mode_t;

  class pixel_scoreboard;
    bit        comp = 1'b0;
    bit        alpha_on = 1'b0;
    bit [15:0] width = 16'd1;
    bit [15:0] height = 16'd1;

    bit        hdr_due = 1'b1;
    bit        run_pkt = 1'b0;
    bit [7:0]  pkt_left = 8'd0;
    bit [1:0]  byte_idx = 2'd0;
    bit [7:0]  color[3];
    bit [31:0] done_cnt = 32'd0;

    pixel_t    exp_q[$];
    int        errors = 0;
    int        checked = 0;
    int        images = 0;
    int        clipped = 0;

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(input cfg_reg_t idx, input bit [15:0] v);
      case (idx)
        REG_COMPRESSED:    comp = v[0];
        REG_ALPHA_PRESENT: alpha_on = v[0];
        REG_IMAGE_WIDTH:   width = v;
        REG_IMAGE_HEIGHT:  height = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void note_byte(input bit [7:0] b);
      bit [31:0] w, h, total, remaining, rpt, pkt;
      bit        ovr;
      bit [7:0]  a;
      pixel_t    p;
      a = 8'd0;
      w = (width == 0) ? 32'd1 : 32'(width);
      h = (height == 0) ? 32'd1 : 32'(height);
      total = w * h;
      if (comp && hdr_due) begin
        run_pkt = b[HDR_RUN_BIT];
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        hdr_due = 1'b0;
        byte_idx = 2'd0;
        return;
      end
      if (byte_idx < 2'd3) begin
        color[byte_idx] = b;
        byte_idx++;
        if (byte_idx < 2'd3 || alpha_on)
          return;
      end else begin
        a = alpha_on ? b : 8'd0;
      end
      byte_idx = 2'd0;
      remaining = (done_cnt < total) ? total - done_cnt : 32'd1;
      if (comp) begin
        pkt = (pkt_left != 0) ? 32'(pkt_left) : 32'd1;
        rpt = run_pkt ? pkt : 32'd1;
        ovr = (pkt > remaining);
        if (run_pkt || pkt <= 1) begin
          pkt_left = 8'd0;
          hdr_due = 1'b1;
        end else begin
          pkt_left = 8'(pkt - 1);
        end
      end else begin
        rpt = 32'd1;
        ovr = 1'b0;
      end
      if (rpt > remaining)
        rpt = remaining;
      p.red = color[2];
      p.green = color[1];
      p.blue = color[0];
      p.alpha = a;
      p.rep = rpt[7:0];
      p.ovr = ovr;
      p.done = (rpt >= remaining);
      exp_q.push_back(p);
      if (p.done) begin
        hdr_due = 1'b1;
        run_pkt = 1'b0;
        pkt_left = 8'd0;
        byte_idx = 2'd0;
        done_cnt = 32'd0;
      end else begin
        done_cnt += rpt;
      end
    endfunction

    task check_pixel(input logic [OUT_DATA_W-1:0] d, input logic [OUT_USER_W-1:0] u);
      pixel_t e;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected pixel data %h user %b", d, u));
        return;
      end
      e = exp_q.pop_front();
      if (d[7:0] !== e.red)
        report($sformatf("pixel %0d red %h expected %h", checked, d[7:0], e.red));
      if (d[15:8] !== e.green)
        report($sformatf("pixel %0d green %h expected %h", checked, d[15:8], e.green));
      if (d[23:16] !== e.blue)
        report($sformatf("pixel %0d blue %h expected %h", checked, d[23:16], e.blue));
      if (d[31:24] !== e.alpha)
        report($sformatf("pixel %0d alpha %h expected %h", checked, d[31:24], e.alpha));
      if (d[39:32] !== e.rep)
        report($sformatf("pixel %0d repeat %0d expected %0d", checked, d[39:32], e.rep));
      if (u[0] !== e.done)
        report($sformatf("pixel %0d image_done %b expected %b", checked, u[0], e.done));
      if (u[1] !== e.ovr)
        report($sformatf("pixel %0d overrun %b expected %b", checked, u[1], e.ovr));
      if (e.done)
        images++;
      if (e.ovr)
        clipped++;
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;      // data_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // red, green, blue, alpha, repeat_count
  logic [OUT_USER_W-1:0] out_tuser;          // image_done, overrun
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

  pixel_scoreboard sb = new;
  rdy_mode_t       rdy_mode = RDY_ALWAYS;
  int              rdy_cnt = 0;
  int              idle_cycles = 0;
  int              bytes_sent = 0;
  int              settings = 0;

  tga_rle_pixel_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rdy_cnt <= rdy_cnt + 1;
    case (rdy_mode)
      RDY_ALWAYS:   out_tready <= 1'b1;
      RDY_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: out_tready <= ((rdy_cnt % 7) >= 2);
      default:      out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d pixels outstanding", sb.pending());
        $display("[tga_rle_pixel_decoder] ERROR");
        $finish;
      end
    end
  end

  task send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task write_reg(input cfg_reg_t idx, input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // sender holds off until every pixel is back and the pipeline is quiet
  task settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [15:0] pick_dim();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0)
      return 16'd0;
    else if (k == 1)
      return 16'hFFFF;
    else if (k == 2)
      return 16'($urandom_range(1, 65535));
    else
      return 16'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [7:0]  dseq[$];
    logic [7:0]  b;
    logic [15:0] rv;
    logic        c, a;
    logic [15:0] w, h;
    int          phase, n, burst, gap, rand_sent, cnt;
    bit          gap_on;

    rand_sent = 0;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: raw 24-bit, one pixel image
    dseq = {8'h00, 8'hFF, 8'h80};
    foreach (dseq[i]) send_byte(dseq[i]);
    settle();
    write_reg(REG_COMPRESSED, 16'h0001);
    write_reg(REG_ALPHA_PRESENT, 16'h0000);
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    settings += 2;
    // single run, full literal clipped at image end, longest run clipped
    dseq = {8'h80, 8'h01, 8'h02, 8'h03,
            8'h7F, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h12, 8'h34, 8'h56,
            8'hFF, 8'h00, 8'hFF, 8'h00};
    foreach (dseq[i]) send_byte(dseq[i]);
    settle();
    // alpha dropped between third and fourth byte
    write_reg(REG_ALPHA_PRESENT, 16'h0001);
    dseq = {8'h00, 8'hAA, 8'h55, 8'hFF};
    foreach (dseq[i]) send_byte(dseq[i]);
    settle();
    write_reg(REG_ALPHA_PRESENT, 16'h0000);
    send_byte(8'h7E);

    while (rand_sent < RANDOM_BYTES) begin
      settle();
      case (phase)
        0: begin c = 1'b1; a = 1'b1; w = 16'hFFFF; h = 16'hFFFF; end
        1: begin c = 1'b0; a = 1'b1; w = 16'd1;    h = 16'd1;    end
        2: begin c = 1'b1; a = 1'b0; w = 16'd0;    h = 16'd3;    end
        3: begin c = 1'b1; a = 1'b1; w = 16'd2;    h = 16'd0;    end
        default: begin
          c = 1'($urandom_range(0, 2) != 0);
          a = 1'($urandom_range(0, 1));
          w = pick_dim();
          h = pick_dim();
        end
      endcase
      rv = 16'($urandom);
      write_reg(REG_COMPRESSED, {rv[15:1], c});
      rv = 16'($urandom);
      write_reg(REG_ALPHA_PRESENT, {rv[15:1], a});
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      settings++;
      rdy_mode <= rdy_mode_t'(phase % 4);
      gap_on = (phase % 3 != 1);
      burst = 0;
      n = $urandom_range(40, 110);
      repeat (n) begin
        if (gap_on && burst == 0) begin
          gap = $urandom_range(0, 12);
          burst = $urandom_range(1, 30);
          if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        if (burst > 0)
          burst--;
        if (sb.comp && sb.hdr_due) begin
          gap = $urandom_range(0, 9);
          if (gap < 6)
            cnt = $urandom_range(0, 3);
          else if (gap < 8)
            cnt = $urandom_range(4, 31);
          else
            cnt = $urandom_range(32, 127);
          b = {1'($urandom_range(0, 1)), 7'(cnt)};
        end else begin
          gap = $urandom_range(0, 15);
          b = (gap == 0) ? 8'h00 : (gap == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        send_byte(b);
        rand_sent++;
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d pixels never arrived", sb.pending()));
    $display("%0d bytes sent under %0d register settings, %0d pixels checked",
             bytes_sent, settings, sb.checked);
    $display("%0d images completed, %0d clipped transactions", sb.images, sb.clipped);
    if (sb.errors == 0)
      $display("[tga_rle_pixel_decoder] OK");
    else
      $display("[tga_rle_pixel_decoder] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_front.sv
hw/rtl/tgad_queue.sv
hw/rtl/tgad_back.sv
hw/rtl/tga_rle_pixel_decoder.sv
verif/tga_rle_pixel_decoder_tb.sv
